// ===== src/cwsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwsm_pkg
// Shared widths, reset values, saturation limits, register indexes, controller states and the
// command and status bundles of the centre-weighted stencil mean.
// ----------------------------------------------------------------------------
package cwsm_pkg;

   localparam int unsigned MAX_STENCIL_DEF = 64;

   localparam int unsigned SAMPLE_W   = 32;
   localparam int unsigned WEIGHT_W   = 16;
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [WEIGHT_W-1:0] CENTRE_WEIGHT_RST    = 16'd256;
   localparam logic [WEIGHT_W-1:0] NEIGHBOUR_WEIGHT_RST = 16'd256;

   localparam logic [SAMPLE_W-1:0] MEAN_POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [SAMPLE_W-1:0] MEAN_NEG_LIMIT = 32'h8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CENTRE_WEIGHT    = 4'd0,
      REG_NEIGHBOUR_WEIGHT = 4'd1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_PREP,
      ST_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic accumulate;
      logic prepare;
      logic load_div;
      logic div_step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_item;
      logic rsp_busy;
   } dpath_status_type;

endpackage : cwsm_pkg
`default_nettype wire

// ===== src/cwsm_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwsm_req_if
// Request channel: one stencil value with its end-of-stencil mark.
// ----------------------------------------------------------------------------
interface cwsm_req_if
   import cwsm_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface : cwsm_req_if
`default_nettype wire

// ===== src/cwsm_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwsm_rsp_if
// Response channel: the weighted mean of one stencil and its flags.
// ----------------------------------------------------------------------------
interface cwsm_rsp_if
   import cwsm_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] mean;
   logic                       zero_divisor;
   logic                       clipped;

   modport source (output valid, output mean, output zero_divisor, output clipped,
                   input ready);
   modport sink   (input valid, input mean, input zero_divisor, input clipped,
                   output ready);
endinterface : cwsm_rsp_if
`default_nettype wire

// ===== src/centre_weighted_stencil_mean.sv =====
`default_nettype none
// A value that does not end its stencil is accepted, then accumulated. A closing value is
// accepted and accumulated, the divisor is built, the SUM_W-bit quotient is formed, where
// SUM_W = 48 + clog2(MAX_STENCIL + 1) bits, 55 at MAX_STENCIL = 64, and the response waits
// for a free output register. No request is taken until the previous one is accumulated;
// the bit-serial divider, one quotient bit a cycle, sets the per-stencil cost. Reset is
// synchronous, active high: weights return to 1.0; running sum and response valid clear.
// ----------------------------------------------------------------------------
// centre_weighted_stencil_mean
// Weighted arithmetic mean of one cell's stencil: the centre value by the
// centre weight, every neighbour by the neighbour weight, divided by the sum
// of the weights used.
// ----------------------------------------------------------------------------
module centre_weighted_stencil_mean
   import cwsm_pkg::*;
#(
   parameter int unsigned MAX_STENCIL = MAX_STENCIL_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   cwsm_req_if.sink                   req_chan,
   cwsm_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // the accumulator is wide enough for MAX_STENCIL full-scale products;
   // the divider runs one step for each of its bits
   localparam int unsigned CNT_W = $clog2(MAX_STENCIL + 1);
   localparam int unsigned SUM_W = SAMPLE_W + WEIGHT_W + CNT_W;

   ctrl_cmd_type     cmd;
   dpath_status_type status;

   // sequencer: one request at a time, the division runs to its end before
   // the next request is taken
   cwsm_ctrl #(
      .DIV_STEPS (SUM_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: multiply each request by its weight, accumulate, then divide
   // by the weight sum; the output register lets a new stencil start while
   // the previous mean waits to be taken
   cwsm_dpath #(
      .MAX_STENCIL (MAX_STENCIL)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_chan.sample),
      .req_last         (req_chan.last),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_mean         (rsp_chan.mean),
      .rsp_zero_divisor (rsp_chan.zero_divisor),
      .rsp_clipped      (rsp_chan.clipped),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

endmodule : centre_weighted_stencil_mean
`default_nettype wire

// ===== src/cwsm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwsm_ctrl
// Sequencer: accept, accumulate, prepare the divisor, run the bit-serial
// division and hand the result to the output register.
// ----------------------------------------------------------------------------
module cwsm_ctrl
   import cwsm_pkg::*;
#(
   parameter int unsigned DIV_STEPS = 55
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dpath_status_type status,
   output ctrl_cmd_type          cmd
);

   localparam int unsigned STEP_W = $clog2(DIV_STEPS);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.accumulate = 1'b1;
            state_in       = status.last_item ? ST_PREP : ST_IDLE;
         end
         ST_PREP: begin
            cmd.prepare = 1'b1;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_div = 1'b1;
            step_in      = STEP_W'(DIV_STEPS - 1);
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule : cwsm_ctrl
`default_nettype wire

// ===== src/cwsm_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwsm_dpath
// Weight registers, multiply-accumulate, divisor build, restoring divider
// and output register.
// ----------------------------------------------------------------------------
module cwsm_dpath
   import cwsm_pkg::*;
#(
   parameter int unsigned MAX_STENCIL = MAX_STENCIL_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ctrl_cmd_type               cmd,
   output dpath_status_type                status,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic                       req_last,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0]      rsp_mean,
   output logic                            rsp_zero_divisor,
   output logic                            rsp_clipped,
   input  wire logic                       csr_we,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned CNT_W  = $clog2(MAX_STENCIL + 1);
   localparam int unsigned PROD_W = SAMPLE_W + WEIGHT_W + 1;
   localparam int unsigned SUM_W  = SAMPLE_W + WEIGHT_W + CNT_W;
   localparam int unsigned NPR_W  = WEIGHT_W + CNT_W;
   localparam int unsigned DIV_W  = WEIGHT_W + CNT_W + 1;
   localparam int unsigned HI_W   = SUM_W - SAMPLE_W + 1;

   logic [WEIGHT_W-1:0]     cw_ff, nw_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                    keep_ff, last_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0]        count_ff;
   logic                    dropped_ff;
   logic                    neg_ff, clip_ff;
   logic [NPR_W-1:0]        nprod_ff;
   logic [DIV_W-1:0]        divisor_ff, rem_ff;
   logic [SUM_W-1:0]        quo_ff, mag_in;
   logic                    out_valid_ff;
   logic [SAMPLE_W-1:0]     mean_ff, mean_in;
   logic                    zdiv_ff, clipped_ff, clipped_in;

   logic [WEIGHT_W-1:0]     weight_sel;
   logic [DIV_W:0]          shifted, trial;
   logic [HI_W-1:0]         quo_hi;
   logic                    zdiv_in, over;

   // weight registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff <= CENTRE_WEIGHT_RST;
         nw_ff <= NEIGHBOUR_WEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_CENTRE_WEIGHT:    cw_ff <= csr_wdata;
            REG_NEIGHBOUR_WEIGHT: nw_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign weight_sel = (count_ff == '0) ? cw_ff : nw_ff;
   assign prod_in    = PROD_W'(req_sample) * PROD_W'($signed({1'b0, weight_sel}));
   assign mag_in     = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign trial   = shifted - {1'b0, divisor_ff};

   // per-stencil state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else if (cmd.accumulate) begin
         if (keep_ff) begin
            sum_ff   <= sum_ff + {{(SUM_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
            count_ff <= count_ff + 1'b1;
         end else begin
            dropped_ff <= 1'b1;
         end
      end else if (cmd.prepare) begin
         sum_ff     <= '0;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         prod_ff <= prod_in;
         keep_ff <= (count_ff < CNT_W'(MAX_STENCIL));
         last_ff <= req_last;
      end
      if (cmd.prepare) begin
         neg_ff   <= sum_ff[SUM_W-1];
         clip_ff  <= dropped_ff;
         nprod_ff <= NPR_W'(nw_ff) * NPR_W'(count_ff - 1'b1);
      end
      if (cmd.load_div) begin
         divisor_ff <= DIV_W'(cw_ff) + DIV_W'(nprod_ff);
         rem_ff     <= '0;
      end
      if (cmd.prepare) begin
         quo_ff <= mag_in;
      end else if (cmd.div_step) begin
         if (!trial[DIV_W]) begin
            rem_ff <= trial[DIV_W-1:0];
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DIV_W-1:0];
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   // saturate and apply the sign
   assign quo_hi  = quo_ff[SUM_W-1:SAMPLE_W-1];
   assign zdiv_in = (divisor_ff == '0);

   always_comb begin
      if (neg_ff) begin
         over = (quo_hi > HI_W'(1)) ||
                ((quo_hi == HI_W'(1)) && (quo_ff[SAMPLE_W-2:0] != '0));
      end else begin
         over = (quo_hi != '0);
      end
      if (zdiv_in) begin
         mean_in = '0;
      end else if (neg_ff) begin
         mean_in = over ? MEAN_NEG_LIMIT : (~quo_ff[SAMPLE_W-1:0] + 1'b1);
      end else begin
         mean_in = over ? MEAN_POS_LIMIT : quo_ff[SAMPLE_W-1:0];
      end
      clipped_in = clip_ff | (!zdiv_in & over);
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         mean_ff    <= mean_in;
         zdiv_ff    <= zdiv_in;
         clipped_ff <= clipped_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_mean         = $signed(mean_ff);
   assign rsp_zero_divisor = zdiv_ff;
   assign rsp_clipped      = clipped_ff;

   assign status.last_item = last_ff;
   assign status.rsp_busy  = out_valid_ff & ~rsp_ready;

endmodule : cwsm_dpath
`default_nettype wire

// ===== src/cwsm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwsm_checker
// Port-level checks of the stencil mean, bound to the top level.
// ----------------------------------------------------------------------------
module cwsm_checker
   import cwsm_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic signed [SAMPLE_W-1:0] rsp_mean,
   input wire logic                       rsp_zero_divisor
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_zero_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_divisor |-> rsp_mean == '0)
      else $error("zero divisor with a non-zero mean");

   a_accum_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !$rose(rsp_valid))
      else $error("request taken during accumulation");

endmodule : cwsm_checker

bind centre_weighted_stencil_mean cwsm_checker u_cwsm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_mean         (rsp_chan.mean),
   .rsp_zero_divisor (rsp_chan.zero_divisor)
);
`default_nettype wire
